FILE: src/trzb_pkg.sv
// shared types, constants and defaults of the triangle rasterizer
`default_nettype none

package trzb_pkg;

	localparam int DEF_FB_WIDTH      = 512;
	localparam int DEF_FB_HEIGHT     = 512;
	localparam int DEF_DEPTH_BITS    = 24;
	localparam int DEF_SUBPIXEL_BITS = 4;

	// barycentric weights carry WFRAC fraction bits, a weight can reach 1.0
	localparam int WFRAC  = 24;
	localparam int WQ     = WFRAC + 1;
	localparam int DIV_CW = $clog2(WQ);

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_VERTEX = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	typedef enum logic [1:0] {
		EDGE_W0,
		EDGE_W1,
		EDGE_AREA
	} edge_sel_t;

	typedef struct packed {
		logic      capture;
		logic      vtx_wr;
		logic [1:0] vtx_idx;
		logic      clr_step;
		logic      rd_host;
		logic      out_load;
		logic      box_init;
		logic      px_first;
		logic      px_next;
		logic      edge_mul;
		logic      edge_sum;
		edge_sel_t edge_sel;
		logic      rd_pix;
		logic      div_init;
		logic      div_step;
		logic      div_store;
		logic      div_sel;
		logic      mac_clr;
		logic      mac_mul;
		logic [1:0] mac_ch;
		logic [1:0] mac_v;
		logic      pix_write;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic box_empty;
		logic area_zero;
		logic covered;
		logic x_last;
		logic y_last;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: src/trzb_dp.sv
// rasterizer datapath: vertex store, edge functions, divider, interpolation, frame memories
`default_nettype none

module trzb_dp #(
	parameter int FB_WIDTH      = trzb_pkg::DEF_FB_WIDTH,
	parameter int FB_HEIGHT     = trzb_pkg::DEF_FB_HEIGHT,
	parameter int DEPTH_BITS    = trzb_pkg::DEF_DEPTH_BITS,
	parameter int SUBPIXEL_BITS = trzb_pkg::DEF_SUBPIXEL_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire trzb_pkg::dp_cmd_t  cmd,
	output trzb_pkg::dp_stat_t      stat,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	input  wire logic [23:0]        vertex_depth,
	input  wire logic [7:0]         vertex_red,
	input  wire logic [7:0]         vertex_green,
	input  wire logic [7:0]         vertex_blue,
	input  wire logic [8:0]         pixel_col,
	input  wire logic [8:0]         pixel_row,
	output logic [7:0]              out_red,
	output logic [7:0]              out_green,
	output logic [7:0]              out_blue,
	output logic [23:0]             out_depth
);
	import trzb_pkg::*;

	localparam int NPIX = FB_WIDTH * FB_HEIGHT;
	localparam int AW   = $clog2(NPIX);
	localparam int XW   = $clog2(FB_WIDTH);
	localparam int YW   = $clog2(FB_HEIGHT);
	localparam int XYW  = (XW > YW) ? XW : YW;
	localparam int PCW  = (XYW + SUBPIXEL_BITS + 2 > 18) ? XYW + SUBPIXEL_BITS + 2 : 18;
	localparam int DW   = PCW + 1;
	localparam int KW   = 18;
	localparam int MW   = KW + DW;
	localparam int EW   = MW + 1;
	localparam int PW   = WQ + DEPTH_BITS;
	localparam int ACW  = PW + 2;
	localparam int ZW   = ACW - WFRAC;

	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
	localparam logic signed [17:0] ROUND_UP = 18'((1 << SUBPIXEL_BITS) - 1);
	localparam logic signed [17:0] X_LIM    = 18'(FB_WIDTH - 1);
	localparam logic signed [17:0] Y_LIM    = 18'(FB_HEIGHT - 1);
	localparam logic [WQ-1:0]  W_ONE = WQ'(1) << WFRAC;
	localparam logic [ACW-1:0] HALF  = ACW'(1) << (WFRAC - 1);

	// vertex store
	logic signed [15:0]    vx_q [3];
	logic signed [15:0]    vy_q [3];
	logic [DEPTH_BITS-1:0] vz_q [3];
	logic [7:0]            vr_q [3];
	logic [7:0]            vg_q [3];
	logic [7:0]            vb_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				vx_q[i] <= '0;
				vy_q[i] <= '0;
				vz_q[i] <= '0;
				vr_q[i] <= '0;
				vg_q[i] <= '0;
				vb_q[i] <= '0;
			end
		end else if (cmd.vtx_wr) begin
			vx_q[cmd.vtx_idx] <= pos_x;
			vy_q[cmd.vtx_idx] <= pos_y;
			vz_q[cmd.vtx_idx] <= DEPTH_BITS'(vertex_depth);
			vr_q[cmd.vtx_idx] <= vertex_red;
			vg_q[cmd.vtx_idx] <= vertex_green;
			vb_q[cmd.vtx_idx] <= vertex_blue;
		end
	end

	// read address capture
	logic [8:0] col_q, row_q;
	logic       in_frame;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			col_q <= pixel_col;
			row_q <= pixel_row;
		end
	end

	assign in_frame = (32'(col_q) < FB_WIDTH) && (32'(row_q) < FB_HEIGHT);

	// bounding box
	function automatic logic signed [17:0] min3(input logic signed [15:0] a, b, c);
		logic signed [15:0] m;
		m = (a < b) ? a : b;
		m = (m < c) ? m : c;
		return 18'(m);
	endfunction

	function automatic logic signed [17:0] max3(input logic signed [15:0] a, b, c);
		logic signed [15:0] m;
		m = (a > b) ? a : b;
		m = (m > c) ? m : c;
		return 18'(m);
	endfunction

	logic signed [17:0] x_lo, x_hi, y_lo, y_hi;
	logic signed [17:0] x_lo_c, x_hi_c, y_lo_c, y_hi_c;

	always_comb begin
		x_lo   = min3(vx_q[0], vx_q[1], vx_q[2]) >>> SUBPIXEL_BITS;
		y_lo   = min3(vy_q[0], vy_q[1], vy_q[2]) >>> SUBPIXEL_BITS;
		x_hi   = (max3(vx_q[0], vx_q[1], vx_q[2]) + ROUND_UP) >>> SUBPIXEL_BITS;
		y_hi   = (max3(vy_q[0], vy_q[1], vy_q[2]) + ROUND_UP) >>> SUBPIXEL_BITS;
		x_lo_c = (x_lo < 0) ? 18'sd0 : x_lo;
		y_lo_c = (y_lo < 0) ? 18'sd0 : y_lo;
		x_hi_c = (x_hi > X_LIM) ? X_LIM : x_hi;
		y_hi_c = (y_hi > Y_LIM) ? Y_LIM : y_hi;
	end

	logic [XW-1:0] x0_q, x1_q, x_q;
	logic [YW-1:0] y0_q, y1_q, y_q;
	logic          box_empty_q;

	always_ff @(posedge clk) begin
		if (cmd.box_init) begin
			x0_q        <= x_lo_c[XW-1:0];
			x1_q        <= x_hi_c[XW-1:0];
			y0_q        <= y_lo_c[YW-1:0];
			y1_q        <= y_hi_c[YW-1:0];
			box_empty_q <= (x_lo_c > x_hi_c) || (y_lo_c > y_hi_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (cmd.px_first) begin
			x_q <= x0_q;
			y_q <= y0_q;
		end else if (cmd.px_next) begin
			if (x_q == x1_q) begin
				x_q <= x0_q;
				y_q <= y_q + YW'(1);
			end else begin
				x_q <= x_q + XW'(1);
			end
		end
	end

	// edge functions on doubled coordinates
	function automatic logic signed [PCW-1:0] dbl(input logic signed [15:0] v);
		logic signed [PCW-1:0] t;
		t = PCW'(v);
		return t <<< 1;
	endfunction

	function automatic logic signed [KW-1:0] kdiff(input logic signed [15:0] a, b);
		logic signed [KW-1:0] t;
		t = KW'(a) - KW'(b);
		return t <<< 1;
	endfunction

	logic [PCW-1:0]        pxu, pyu;
	logic signed [PCW-1:0] px, py, ax, ay, cx, cy;
	logic signed [DW-1:0]  dpx, dpy, dax, day, d0, d1;
	logic signed [KW-1:0]  k0, k1;

	always_comb begin
		pxu = PCW'({x_q, 1'b1}) << SUBPIXEL_BITS;
		pyu = PCW'({y_q, 1'b1}) << SUBPIXEL_BITS;
		px  = signed'(pxu);
		py  = signed'(pyu);
		ax  = dbl(vx_q[0]);
		ay  = dbl(vy_q[0]);
		cx  = dbl(vx_q[2]);
		cy  = dbl(vy_q[2]);
		dpx = DW'(px) - DW'(cx);
		dpy = DW'(py) - DW'(cy);
		dax = DW'(ax) - DW'(cx);
		day = DW'(ay) - DW'(cy);
		case (cmd.edge_sel)
			EDGE_W1: begin
				k0 = kdiff(vy_q[2], vy_q[0]);
				k1 = kdiff(vx_q[0], vx_q[2]);
				d0 = dpx;
				d1 = dpy;
			end
			EDGE_AREA: begin
				k0 = kdiff(vy_q[1], vy_q[2]);
				k1 = kdiff(vx_q[2], vx_q[1]);
				d0 = dax;
				d1 = day;
			end
			default: begin
				k0 = kdiff(vy_q[1], vy_q[2]);
				k1 = kdiff(vx_q[2], vx_q[1]);
				d0 = dpx;
				d1 = dpy;
			end
		endcase
	end

	logic signed [MW-1:0] m0_q, m1_q;
	logic signed [EW-1:0] esum, eneg, w0_q, w1_q, area_q, w2;
	logic                 neg_q;

	assign esum = EW'(m0_q) + EW'(m1_q);
	assign eneg = -esum;

	always_ff @(posedge clk) begin
		if (cmd.edge_mul) begin
			m0_q <= k0 * d0;
			m1_q <= k1 * d1;
		end
		if (cmd.edge_sum) begin
			case (cmd.edge_sel)
				EDGE_AREA: begin
					area_q <= esum[EW-1] ? eneg : esum;
					neg_q  <= esum[EW-1];
				end
				EDGE_W1: w1_q <= neg_q ? eneg : esum;
				default: w0_q <= neg_q ? eneg : esum;
			endcase
		end
	end

	assign w2 = area_q - w0_q - w1_q;

	// restoring divider, one quotient bit a cycle
	logic [EW-1:0] rem_q;
	logic [EW:0]   diff;
	logic [WQ-1:0] q_q, wa_q, wb_q, wg;

	assign diff = {1'b0, rem_q} - {1'b0, $unsigned(area_q)};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= cmd.div_sel ? $unsigned(w1_q) : $unsigned(w0_q);
			q_q   <= '0;
		end else if (cmd.div_step) begin
			if (!diff[EW]) begin
				rem_q <= {diff[EW-2:0], 1'b0};
				q_q   <= {q_q[WQ-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[EW-2:0], 1'b0};
				q_q   <= {q_q[WQ-2:0], 1'b0};
			end
		end
		if (cmd.div_store) begin
			if (cmd.div_sel) begin
				wb_q <= q_q;
			end else begin
				wa_q <= q_q;
			end
		end
	end

	assign wg = W_ONE - wa_q - wb_q;

	// shared multiply-accumulate for depth and the three channels
	logic [WQ-1:0]         wsel;
	logic [DEPTH_BITS-1:0] vsel;
	logic [PW-1:0]         prod_s1;
	logic [1:0]            prod_ch_s1;
	logic                  prod_vld_s1;
	logic [ACW-1:0]        acc_q [4];

	always_comb begin
		case (cmd.mac_v)
			2'd0:    wsel = wa_q;
			2'd1:    wsel = wb_q;
			default: wsel = wg;
		endcase
		case (cmd.mac_ch)
			2'd0:    vsel = vz_q[cmd.mac_v];
			2'd1:    vsel = DEPTH_BITS'(vr_q[cmd.mac_v]);
			2'd2:    vsel = DEPTH_BITS'(vg_q[cmd.mac_v]);
			default: vsel = DEPTH_BITS'(vb_q[cmd.mac_v]);
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mac_mul) begin
			prod_s1    <= wsel * vsel;
			prod_ch_s1 <= cmd.mac_ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
		end else begin
			prod_vld_s1 <= cmd.mac_mul;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mac_clr) begin
			for (int i = 0; i < 4; i++) begin
				acc_q[i] <= '0;
			end
		end else if (prod_vld_s1) begin
			acc_q[prod_ch_s1] <= acc_q[prod_ch_s1] + ACW'(prod_s1);
		end
	end

	function automatic logic [7:0] sat_chan(input logic [ACW-1:0] a);
		logic [ACW-1:0] t;
		logic [ZW-1:0]  s;
		t = a + HALF;
		s = t[ACW-1:WFRAC];
		return (|s[ZW-1:8]) ? 8'hFF : s[7:0];
	endfunction

	logic [ZW-1:0]         zs;
	logic [DEPTH_BITS-1:0] z;
	logic [23:0]           pix_color;

	always_comb begin
		zs        = acc_q[0][ACW-1:WFRAC];
		z         = (|zs[ZW-1:DEPTH_BITS]) ? DEPTH_MAX : zs[DEPTH_BITS-1:0];
		pix_color = {sat_chan(acc_q[1]), sat_chan(acc_q[2]), sat_chan(acc_q[3])};
	end

	// frame memories, one write and one registered read a cycle
	logic [DEPTH_BITS-1:0] depth_mem [NPIX];
	logic [23:0]           color_mem [NPIX];
	logic [DEPTH_BITS-1:0] depth_rd_q;
	logic [23:0]           color_rd_q;
	logic [AW-1:0]         clr_addr_q, pix_addr, host_addr, rd_addr, wr_addr;
	logic                  rd_en, wr_en;
	logic [DEPTH_BITS-1:0] wr_depth;
	logic [23:0]           wr_color;

	always_comb begin
		pix_addr  = AW'(y_q) * AW'(FB_WIDTH) + AW'(x_q);
		host_addr = AW'(row_q) * AW'(FB_WIDTH) + AW'(col_q);
		rd_addr   = cmd.rd_host ? host_addr : pix_addr;
		rd_en     = cmd.rd_host || cmd.rd_pix;
		wr_en     = cmd.clr_step || (cmd.pix_write && (z < depth_rd_q));
		wr_addr   = cmd.clr_step ? clr_addr_q : pix_addr;
		wr_depth  = cmd.clr_step ? DEPTH_MAX : z;
		wr_color  = cmd.clr_step ? 24'd0 : pix_color;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			depth_mem[wr_addr] <= wr_depth;
			color_mem[wr_addr] <= wr_color;
		end
		if (rd_en) begin
			depth_rd_q <= depth_mem[rd_addr];
			color_rd_q <= color_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_addr_q <= stat.clr_last ? '0 : clr_addr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_red   <= in_frame ? color_rd_q[23:16] : 8'd0;
			out_green <= in_frame ? color_rd_q[15:8] : 8'd0;
			out_blue  <= in_frame ? color_rd_q[7:0] : 8'd0;
			out_depth <= in_frame ? 24'(depth_rd_q) : 24'd0;
		end
	end

	always_comb begin
		stat.clr_last  = clr_addr_q == AW'(NPIX - 1);
		stat.box_empty = box_empty_q;
		stat.area_zero = area_q == '0;
		stat.covered   = !w0_q[EW-1] && !w1_q[EW-1] && !w2[EW-1];
		stat.x_last    = x_q == x1_q;
		stat.y_last    = y_q == y1_q;
	end

endmodule

`default_nettype wire

FILE: src/trzb_ctrl.sv
// rasterizer controller: command decode, box walk and per-pixel sequencing
`default_nettype none

module trzb_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [1:0]        opcode,
	input  wire trzb_pkg::dp_stat_t stat,
	output trzb_pkg::dp_cmd_t      cmd,
	output logic                   busy,
	output logic                   done
);
	import trzb_pkg::*;

	localparam logic [1:0] LAST_VTX = 2'd2;
	localparam logic [1:0] LAST_CH  = 2'd3;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ_ISSUE,
		ST_READ_WAIT,
		ST_BOX,
		ST_AREA_MUL,
		ST_AREA_SUM,
		ST_AREA_CHK,
		ST_PIX_MUL0,
		ST_PIX_SUM0,
		ST_PIX_MUL1,
		ST_PIX_SUM1,
		ST_PIX_TEST,
		ST_DIV_INIT,
		ST_DIV_RUN,
		ST_DIV_END,
		ST_MAC_RUN,
		ST_MAC_TAIL,
		ST_PIX_WRITE,
		ST_PIX_NEXT
	} state_t;

	state_t            state_q;
	logic [1:0]        vtx_cnt_q;
	logic [DIV_CW-1:0] div_cnt_q;
	logic              div_sel_q;
	logic [1:0]        mac_ch_q, mac_v_q;
	logic              done_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					cmd.vtx_wr  = opcode == OP_VERTEX;
					cmd.vtx_idx = vtx_cnt_q;
				end
			end
			ST_CLEAR:      cmd.clr_step = 1'b1;
			ST_READ_ISSUE: cmd.rd_host  = 1'b1;
			ST_READ_WAIT:  cmd.out_load = 1'b1;
			ST_BOX:        cmd.box_init = 1'b1;
			ST_AREA_MUL: begin
				cmd.edge_mul = 1'b1;
				cmd.edge_sel = EDGE_AREA;
				cmd.px_first = 1'b1;
			end
			ST_AREA_SUM: begin
				cmd.edge_sum = 1'b1;
				cmd.edge_sel = EDGE_AREA;
			end
			ST_PIX_MUL0: begin
				cmd.edge_mul = 1'b1;
				cmd.edge_sel = EDGE_W0;
				cmd.rd_pix   = 1'b1;
			end
			ST_PIX_SUM0: begin
				cmd.edge_sum = 1'b1;
				cmd.edge_sel = EDGE_W0;
			end
			ST_PIX_MUL1: begin
				cmd.edge_mul = 1'b1;
				cmd.edge_sel = EDGE_W1;
			end
			ST_PIX_SUM1: begin
				cmd.edge_sum = 1'b1;
				cmd.edge_sel = EDGE_W1;
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				cmd.div_sel  = div_sel_q;
			end
			ST_DIV_RUN: cmd.div_step = 1'b1;
			ST_DIV_END: begin
				cmd.div_store = 1'b1;
				cmd.div_sel   = div_sel_q;
				cmd.mac_clr   = div_sel_q;
			end
			ST_MAC_RUN: begin
				cmd.mac_mul = 1'b1;
				cmd.mac_ch  = mac_ch_q;
				cmd.mac_v   = mac_v_q;
			end
			ST_PIX_WRITE: cmd.pix_write = 1'b1;
			ST_PIX_NEXT:  cmd.px_next   = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			vtx_cnt_q <= '0;
			div_cnt_q <= '0;
			div_sel_q <= 1'b0;
			mac_ch_q  <= '0;
			mac_v_q   <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (opcode)
							OP_CLEAR: state_q <= ST_CLEAR;
							OP_VERTEX: begin
								if (vtx_cnt_q == LAST_VTX) begin
									vtx_cnt_q <= '0;
									state_q   <= ST_BOX;
								end else begin
									vtx_cnt_q <= vtx_cnt_q + 2'd1;
								end
							end
							OP_READ: state_q <= ST_READ_ISSUE;
							default: ;
						endcase
					end
				end
				ST_CLEAR: begin
					if (stat.clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_READ_ISSUE: state_q <= ST_READ_WAIT;
				ST_READ_WAIT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_BOX:      state_q <= ST_AREA_MUL;
				ST_AREA_MUL: state_q <= ST_AREA_SUM;
				ST_AREA_SUM: state_q <= ST_AREA_CHK;
				ST_AREA_CHK: begin
					state_q <= (stat.box_empty || stat.area_zero) ? ST_IDLE : ST_PIX_MUL0;
				end
				ST_PIX_MUL0: state_q <= ST_PIX_SUM0;
				ST_PIX_SUM0: state_q <= ST_PIX_MUL1;
				ST_PIX_MUL1: state_q <= ST_PIX_SUM1;
				ST_PIX_SUM1: state_q <= ST_PIX_TEST;
				ST_PIX_TEST: begin
					div_sel_q <= 1'b0;
					state_q   <= stat.covered ? ST_DIV_INIT : ST_PIX_NEXT;
				end
				ST_DIV_INIT: begin
					div_cnt_q <= '0;
					state_q   <= ST_DIV_RUN;
				end
				ST_DIV_RUN: begin
					if (div_cnt_q == DIV_CW'(WQ - 1)) begin
						state_q <= ST_DIV_END;
					end else begin
						div_cnt_q <= div_cnt_q + DIV_CW'(1);
					end
				end
				ST_DIV_END: begin
					if (!div_sel_q) begin
						div_sel_q <= 1'b1;
						state_q   <= ST_DIV_INIT;
					end else begin
						mac_ch_q <= '0;
						mac_v_q  <= '0;
						state_q  <= ST_MAC_RUN;
					end
				end
				ST_MAC_RUN: begin
					if (mac_v_q == LAST_VTX) begin
						mac_v_q <= '0;
						if (mac_ch_q == LAST_CH) begin
							state_q <= ST_MAC_TAIL;
						end else begin
							mac_ch_q <= mac_ch_q + 2'd1;
						end
					end else begin
						mac_v_q <= mac_v_q + 2'd1;
					end
				end
				ST_MAC_TAIL:  state_q <= ST_PIX_WRITE;
				ST_PIX_WRITE: state_q <= ST_PIX_NEXT;
				ST_PIX_NEXT: begin
					state_q <= (stat.x_last && stat.y_last) ? ST_IDLE : ST_PIX_MUL0;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = state_q != ST_IDLE;
	assign done = done_q;

endmodule

`default_nettype wire

FILE: src/triangle_rasterizer_zbuffer.sv
// top level of the depth-buffered gouraud triangle rasterizer
//
// commands enter on start/opcode and the payload ports; a command transfers at
// a rising edge with start high and busy low.
//   clear  : sweeps both frame memories, one pixel a cycle, no result
//   vertex : every third vertex closes a triangle and starts the raster walk,
//            no result
//   read   : one result from the registered memory read, shown for one cycle
//            with done high; out of frame reads give all zero
// a triangle passes the box, area multiply, area sum and area check states,
// then visits each pixel of its clamped bounding box; an inside pixel also
// takes two restoring divisions for the weights and 12 passes through the
// shared multiplier. the frame memories have one write and one read port
// each, read registered.
// reset starts the same clearing pass as the clear command; busy stays high
// until it ends. the receiver of results cannot stall: a result is taken in
// the cycle that done is high.
`default_nettype none

module triangle_rasterizer_zbuffer #(
	parameter int FB_WIDTH      = trzb_pkg::DEF_FB_WIDTH,
	parameter int FB_HEIGHT     = trzb_pkg::DEF_FB_HEIGHT,
	parameter int DEPTH_BITS    = trzb_pkg::DEF_DEPTH_BITS,
	parameter int SUBPIXEL_BITS = trzb_pkg::DEF_SUBPIXEL_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         opcode,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	input  wire logic [23:0]        vertex_depth,
	input  wire logic [7:0]         vertex_red,
	input  wire logic [7:0]         vertex_green,
	input  wire logic [7:0]         vertex_blue,
	input  wire logic [8:0]         pixel_col,
	input  wire logic [8:0]         pixel_row,
	output logic                    done,
	output logic [7:0]              out_red,
	output logic [7:0]              out_green,
	output logic [7:0]              out_blue,
	output logic [23:0]             out_depth
);
	import trzb_pkg::*;

	// command and status between controller and datapath
	dp_cmd_t  cmd;
	dp_stat_t stat;

	trzb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// geometry, divider, interpolation and the two frame memories
	trzb_dp #(
		.FB_WIDTH      (FB_WIDTH),
		.FB_HEIGHT     (FB_HEIGHT),
		.DEPTH_BITS    (DEPTH_BITS),
		.SUBPIXEL_BITS (SUBPIXEL_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.vertex_depth (vertex_depth),
		.vertex_red   (vertex_red),
		.vertex_green (vertex_green),
		.vertex_blue  (vertex_blue),
		.pixel_col    (pixel_col),
		.pixel_row    (pixel_row),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.out_depth    (out_depth)
	);

	// a result lands only once the controller is back to accepting
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while busy");

	// a read transfer yields its result after the issue and wait states
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_READ) |-> ##3 done)
		else $error("read result missing");

	// other commands never produce a result right after their transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode != OP_READ) |=> !done)
		else $error("result without a read");

endmodule

`default_nettype wire
